// ----- rtl/pil_pkg.sv -----
// ----------------------------------------------------------------------------
// pil_pkg: shared types and codes for the positional insert list
// request and result item layouts, request kinds and result status codes
// ----------------------------------------------------------------------------
package pil_pkg;

  localparam logic [1:0] KIND_FRONT = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_AT    = 2'd2;
  localparam logic [1:0] KIND_POP   = 2'd3;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic        [1:0]  kind;
    logic signed [31:0] value;
    logic        [7:0]  position;
  } in_item_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic signed [31:0] removed_value;
    logic        [4:0]  item_count;
  } out_item_t;

endpackage

// ----- rtl/pil_store.sv -----
// ----------------------------------------------------------------------------
// pil_store: entry memory of the positional insert list
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module pil_store #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/positional_insert_list.sv -----
// ----------------------------------------------------------------------------
// positional_insert_list: bounded ordered list of signed 32-bit values
// entries live in a circular buffer memory; push front, append, insert at
// index and pop front, one result item per request item
// ----------------------------------------------------------------------------
//
//  channel | ports                  | handshake
//  --------+------------------------+---------------------------------------
//  request | start, busy, in_item   | item taken when start high, busy low
//  result  | out_valid, out_item    | one-cycle strobe, always taken
//
// push front, append, insert at index zero or at/after the end, a full-list
//   insert and a pop on an empty list finish in the cycle they are accepted
// pop front passes through S_POP for the synchronous memory read of the head
// insert at index p inside the list walks S_SHIFT; the single memory write
//   port moves one entry per cycle toward the end
// reset clears state, head, count, pend and the result strobe; the entry memory needs no clearing pass
// the result strobe is registered and fires in the cycle after the item finishes;
//   there is no result-side stall
module positional_insert_list #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  pil_pkg::in_item_t  in_item,
  output logic               out_valid,
  output pil_pkg::out_item_t out_item
);

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > 8) ? CW : 8;
  localparam int CXW  = (CW > 5) ? CW : 5;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_POP   = 3'b010,
    S_SHIFT = 3'b100
  } state_t;

  state_t                 state_r, state_nxt;
  logic [AW-1:0]          head_r, head_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [31:0]            req_value_r, req_value_nxt;
  logic [CW-1:0]          pos_r, pos_nxt;
  logic [CW-1:0]          cur_r, cur_nxt;
  logic [CW-1:0]          left_r, left_nxt;
  logic                   pend_r, pend_nxt;
  logic [CW-1:0]          pend_idx_r, pend_idx_nxt;
  logic                   out_valid_r, out_valid_nxt;
  pil_pkg::out_item_t     out_item_r, out_item_nxt;

  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [31:0]            wr_data;
  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  logic [31:0]            rd_data;

  logic                   accept;
  logic [CMPW-1:0]        pos_ext;
  logic [CMPW-1:0]        count_ext;
  logic [CW-1:0]          pos_clamp;
  logic                   full;
  logic [AW-1:0]          head_dec;
  logic [AW-1:0]          head_inc;

  // logical index to physical address in the circular buffer
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                         input logic [CW-1:0] idx);
    logic [CW:0] sum;
    sum = (CW + 1)'(head) + (CW + 1)'(idx);
    if (sum >= (CW + 1)'(CAPACITY)) begin
      sum = sum - (CW + 1)'(CAPACITY);
    end
    return sum[AW-1:0];
  endfunction

  // count shown on the result, masked to the 5-bit field
  function automatic logic [4:0] show_count(input logic [CW-1:0] cnt);
    logic [CXW-1:0] wide;
    wide = CXW'(cnt);
    return wide[4:0];
  endfunction

  pil_store #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign busy   = (state_r != S_IDLE);
  assign accept = start && (state_r == S_IDLE);

  // position past the count lands at the end
  assign pos_ext   = CMPW'(in_item.position);
  assign count_ext = CMPW'(count_r);
  assign pos_clamp = (pos_ext > count_ext) ? count_r : pos_ext[CW-1:0];

  assign full     = (count_r == CW'(CAPACITY));
  assign head_dec = (head_r == '0) ? AW'(CAPACITY - 1) : head_r - AW'(1);
  assign head_inc = (head_r == AW'(CAPACITY - 1)) ? '0 : head_r + AW'(1);

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    req_value_nxt = req_value_r;
    pos_nxt       = pos_r;
    cur_nxt       = cur_r;
    left_nxt      = left_r;
    pend_nxt      = pend_r;
    pend_idx_nxt  = pend_idx_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = in_item.value;
    rd_en         = 1'b0;
    rd_addr       = head_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_item_nxt.removed_value = '0;
          if (in_item.kind == pil_pkg::KIND_POP) begin
            if (count_r == '0) begin
              // pop on empty list
              out_valid_nxt           = 1'b1;
              out_item_nxt.status     = pil_pkg::STATUS_EMPTY;
              out_item_nxt.item_count = show_count(count_r);
            end else begin
              // fetch the head, result from S_POP
              rd_en     = 1'b1;
              rd_addr   = head_r;
              state_nxt = S_POP;
            end
          end else if (full) begin
            // insert dropped, list unchanged
            out_valid_nxt           = 1'b1;
            out_item_nxt.status     = pil_pkg::STATUS_FULL;
            out_item_nxt.item_count = show_count(count_r);
          end else if (in_item.kind == pil_pkg::KIND_FRONT ||
                       (in_item.kind == pil_pkg::KIND_AT && pos_clamp == '0)) begin
            // new head one slot back
            wr_en                   = 1'b1;
            wr_addr                 = head_dec;
            head_nxt                = head_dec;
            count_nxt               = count_r + CW'(1);
            out_valid_nxt           = 1'b1;
            out_item_nxt.status     = pil_pkg::STATUS_DONE;
            out_item_nxt.item_count = show_count(count_r + CW'(1));
          end else if (in_item.kind == pil_pkg::KIND_END || pos_clamp == count_r) begin
            // append right after the tail
            wr_en                   = 1'b1;
            wr_addr                 = phys(head_r, count_r);
            count_nxt               = count_r + CW'(1);
            out_valid_nxt           = 1'b1;
            out_item_nxt.status     = pil_pkg::STATUS_DONE;
            out_item_nxt.item_count = show_count(count_r + CW'(1));
          end else begin
            // inner insert: move the tail part up one slot, last entry first
            req_value_nxt = in_item.value;
            pos_nxt       = pos_clamp;
            cur_nxt       = count_r - CW'(1);
            left_nxt      = count_r - pos_clamp;
            pend_nxt      = 1'b0;
            state_nxt     = S_SHIFT;
          end
        end
      end

      S_POP: begin
        head_nxt                   = head_inc;
        count_nxt                  = count_r - CW'(1);
        out_valid_nxt              = 1'b1;
        out_item_nxt.status        = pil_pkg::STATUS_DONE;
        out_item_nxt.removed_value = rd_data;
        out_item_nxt.item_count    = show_count(count_r - CW'(1));
        state_nxt                  = S_IDLE;
      end

      S_SHIFT: begin
        // write back the entry read last cycle one slot further out
        if (pend_r) begin
          wr_en   = 1'b1;
          wr_addr = phys(head_r, pend_idx_r + CW'(1));
          wr_data = rd_data;
        end
        if (left_r != '0) begin
          // read the next entry down; never the one being written
          rd_en        = 1'b1;
          rd_addr      = phys(head_r, cur_r);
          pend_nxt     = 1'b1;
          pend_idx_nxt = cur_r;
          cur_nxt      = cur_r - CW'(1);
          left_nxt     = left_r - CW'(1);
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            // gap is open, drop the new value in
            wr_en                      = 1'b1;
            wr_addr                    = phys(head_r, pos_r);
            wr_data                    = req_value_r;
            count_nxt                  = count_r + CW'(1);
            out_valid_nxt              = 1'b1;
            out_item_nxt.status        = pil_pkg::STATUS_DONE;
            out_item_nxt.removed_value = '0;
            out_item_nxt.item_count    = show_count(count_r + CW'(1));
            state_nxt                  = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and walk registers, no reset needed
  always_ff @(posedge clk) begin
    req_value_r <= req_value_nxt;
    pos_r       <= pos_nxt;
    cur_r       <= cur_nxt;
    left_r      <= left_nxt;
    pend_idx_r  <= pend_idx_nxt;
    out_item_r  <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
